// ----- sv/byte_ring_buffer_dma_head_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the byte ring buffer
// Implication and next-cycle implication checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_DMA_HEAD_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_DMA_HEAD_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer: same-cycle check failed");

`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer: next-cycle check failed");

`else

`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/brb_pkg.sv -----
// ---------------------------------------------------------------------------
// brb_pkg
// Shared constants, command codes, types and helpers of the byte ring buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  localparam int DEPTH  = 4096;
  localparam int PTR_W  = 12;
  localparam int CNT_W  = 13;
  localparam int DATA_W = 8;
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROP     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STORE    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SET_HEAD = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_CLEAR = 3'b100
  } brb_state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } brb_mem_req_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  fill;
  } brb_res_t;

  // Move a position forward by n with wrap at size; pos < size and n <= size.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
                                               input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] size);
    logic [CNT_W-1:0] sum;
    sum = {1'b0, pos} + n;
    if (sum >= size) begin
      sum = sum - size;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/brb_ram.sv -----
// ---------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/brb_ctrl.sv -----
// ---------------------------------------------------------------------------
// brb_ctrl
// Command decode, ring pointers, fill level and the clear sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module brb_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [brb_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [brb_pkg::DATA_W-1:0]   in_data_in,
  input  wire logic [brb_pkg::PTR_W-1:0]    in_offset,
  input  wire logic [brb_pkg::CNT_W-1:0]    in_count,
  input  wire logic [brb_pkg::PTR_W-1:0]    in_new_head,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [brb_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic                         slot_free,
  input  wire logic [brb_pkg::DATA_W-1:0]   rd_data,
  output brb_pkg::brb_mem_req_t             mem_req,
  output brb_pkg::brb_res_t                 res
);

  import brb_pkg::*;

  brb_state_t       state_r, state_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic [PTR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             accept;
  logic [CNT_W-1:0] added;
  logic [CNT_W:0]   grown;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || !slot_free || cfg_valid;
  assign accept    = in_valid && !in_stall;

  // Bytes the DMA writer has added, counted with wrap.
  always_comb begin
    if (in_new_head >= wp_r) begin
      added = {1'b0, in_new_head} - {1'b0, wp_r};
    end else begin
      added = {1'b0, in_new_head} + size_r - {1'b0, wp_r};
    end
    grown = {1'b0, added} + {1'b0, fill_r};
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    size_nxt    = size_r;
    clr_idx_nxt = clr_idx_r;
    mem_req     = '0;
    res         = '0;

    if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        size_nxt = CNT_W'(1);
      end else if (cfg_data > CNT_W'(DEPTH)) begin
        size_nxt = CNT_W'(DEPTH);
      end else begin
        size_nxt = cfg_data;
      end
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res.valid = 1'b1;
          case (in_kind)
            KIND_PUSH: begin
              if (fill_r < size_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wp_r;
                mem_req.wdata = in_data_in;
                wp_nxt        = advance(wp_r, CNT_W'(1), size_r);
                fill_nxt      = fill_r + CNT_W'(1);
                res.ok        = 1'b1;
              end
            end
            KIND_POP: begin
              if (fill_r != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = rp_r;
                rp_nxt        = advance(rp_r, CNT_W'(1), size_r);
                fill_nxt      = fill_r - CNT_W'(1);
                res.valid     = 1'b0;
                state_nxt     = ST_READ;
              end
            end
            KIND_PEEK: begin
              if ({1'b0, in_offset} < fill_r) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = advance(rp_r, {1'b0, in_offset}, size_r);
                res.valid     = 1'b0;
                state_nxt     = ST_READ;
              end
            end
            KIND_DROP: begin
              if (in_count <= fill_r) begin
                rp_nxt   = advance(rp_r, in_count, size_r);
                fill_nxt = fill_r - in_count;
                res.ok   = 1'b1;
              end
            end
            KIND_CLEAR: begin
              wp_nxt      = '0;
              rp_nxt      = '0;
              fill_nxt    = '0;
              clr_idx_nxt = '0;
              res.ok      = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            KIND_STORE: begin
              if ({1'b0, in_offset} < size_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_offset;
                mem_req.wdata = in_data_in;
                res.ok        = 1'b1;
              end
            end
            KIND_SET_HEAD: begin
              if ({1'b0, in_new_head} < size_r) begin
                // Overrun: the ring is full and the oldest byte sits at the head.
                if (grown > {1'b0, size_r}) begin
                  rp_nxt   = in_new_head;
                  fill_nxt = size_r;
                end else begin
                  fill_nxt = grown[CNT_W-1:0];
                end
                wp_nxt = in_new_head;
                res.ok = 1'b1;
              end
            end
            default: begin
              res.ok = 1'b0;
            end
          endcase
          res.fill = fill_nxt;
        end
      end
      ST_READ: begin
        // The fill level was already updated when the command was taken.
        res.valid = 1'b1;
        res.ok    = 1'b1;
        res.data  = rd_data;
        res.fill  = fill_r;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_idx_r;
        mem_req.wdata = '0;
        clr_idx_nxt   = clr_idx_r + PTR_W'(1);
        if ({1'b0, clr_idx_r} == size_r - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      fill_r  <= '0;
      size_r  <= CNT_W'(DEPTH);
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_idx_r <= clr_idx_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/byte_ring_buffer_dma_head_top.sv -----
// ---------------------------------------------------------------------------
// byte_ring_buffer_dma_head_top
// Byte ring buffer with push, pop, peek, drop, clear, raw store and DMA head.
// ---------------------------------------------------------------------------
// Each word on the input channel is one command and yields exactly one result
// word. Push, drop, store, set head, unknown codes and failed commands finish in
// the cycle they are taken; pop and peek wait for the registered read of the byte
// memory; clear zeroes the first buffer_size entries one entry per cycle through
// the memory's single write port, and the input stalls until it ends. The result
// sits in an output register; while it waits under out_stall the input is stalled
// as well, and the next command is taken in the cycle the waiting word leaves.
// There is no clearing pass after reset: bytes read before they were ever
// written are undefined. Writing buffer_size (0 reads as 1, above 4096 as
// 4096) empties the ring but keeps the stored bytes.
`default_nettype none
`include "byte_ring_buffer_dma_head_top_macros.svh"

module byte_ring_buffer_dma_head_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [brb_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [brb_pkg::DATA_W-1:0]   in_data_in,
  input  wire logic [brb_pkg::PTR_W-1:0]    in_offset,
  input  wire logic [brb_pkg::CNT_W-1:0]    in_count,
  input  wire logic [brb_pkg::PTR_W-1:0]    in_new_head,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_ok,
  output logic      [brb_pkg::DATA_W-1:0]   out_data_out,
  output logic      [brb_pkg::CNT_W-1:0]    out_fill_level,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [brb_pkg::CNT_W-1:0]    cfg_data
);

  import brb_pkg::*;

  brb_mem_req_t      mem_req;
  brb_res_t          res;
  logic [DATA_W-1:0] rd_data;
  logic              slot_free;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_fill_r;

  assign slot_free = !out_valid_r || !out_stall;

  brb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_data_in  (in_data_in),
    .in_offset   (in_offset),
    .in_count    (in_count),
    .in_new_head (in_new_head),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .slot_free   (slot_free),
    .rd_data     (rd_data),
    .mem_req     (mem_req),
    .res         (res)
  );

  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  always_comb begin
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_ok_r   <= res.ok;
      out_data_r <= res.data;
      out_fill_r <= res.fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_data_out   = out_data_r;
  assign out_fill_level = out_fill_r;

  // A new result never lands on a word that is still waiting to be taken.
  `BRB_ASSERT_IMPL(a_no_overwrite, clk, rst_n, res.valid, slot_free)
  // Every memory read turns into a result in the following cycle.
  `BRB_ASSERT_NEXT(a_read_result, clk, rst_n, mem_req.re, res.valid && res.ok)
  // The reported fill level never exceeds the store.
  `BRB_ASSERT_IMPL(a_fill_bound, clk, rst_n, out_valid_r, out_fill_r <= CNT_W'(DEPTH))

endmodule

`default_nettype wire
